>>> hw/rtl/bounded_stack_with_search_top_macros.svh
`ifndef BOUNDED_STACK_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication under reset
`define BSWS_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("stack check failed");

// next-cycle implication under reset
`define BSWS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("stack check failed");

`endif

>>> hw/rtl/bsws_pkg.sv
package bsws_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_WORD = 32'shFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic rd_sel_scan;
        logic scan_issue;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_more;
        logic cmp_pending;
    } dp_status_t;

endpackage

>>> hw/rtl/bsws_datapath.sv
module bsws_datapath #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsws_pkg::dp_cmd_t    cmd,
    input  logic [1:0]           operation,
    input  logic signed [31:0]   value,
    output bsws_pkg::dp_status_t sts,
    output logic signed [31:0]   popped_word,
    output logic                 found,
    output logic [1:0]           status
);
    import bsws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];

    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               hit_reg, hit_next;
    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         rstat_reg, rstat_next;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] word_reg, word_next;
    logic               found_reg, found_next;
    logic [1:0]         status_reg;

    logic               full;
    logic               empty;
    logic [CW-1:0]      fill_m1;
    logic [AW-1:0]      rd_addr;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign fill_m1 = fill_reg - CW'(1);
    assign rd_addr = cmd.rd_sel_scan ? idx_reg[AW-1:0] : fill_m1[AW-1:0];

    always_comb
    begin
        fill_next  = fill_reg;
        rstat_next = rstat_reg;
        if (cmd.accept)
        begin
            rstat_next = STAT_OK;
            case (operation)
                OP_PUSH:
                begin
                    if (full)
                        rstat_next = STAT_FULL;
                    else
                        fill_next = fill_reg + CW'(1);
                end
                OP_POP:
                begin
                    if (empty)
                        rstat_next = STAT_EMPTY;
                    else
                        fill_next = fill_m1;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        cmp_vld_next = cmd.scan_issue;
        if (cmd.accept)
        begin
            idx_next = '0;
            hit_next = 1'b0;
        end
        else
        begin
            if (cmd.scan_issue)
                idx_next = idx_reg + CW'(1);
            if (cmp_vld_reg && (rdata_reg == val_reg))
                hit_next = 1'b1;
        end
    end

    always_comb
    begin
        word_next  = '0;
        found_next = 1'b0;
        case (op_reg)
            OP_POP:
            begin
                word_next = (rstat_reg == STAT_EMPTY) ? EMPTY_WORD : rdata_reg;
            end
            OP_SEARCH:
            begin
                found_next = hit_reg;
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            rstat_reg   <= STAT_OK;
        end
        else
        begin
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            rstat_reg   <= rstat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
        if (cmd.load_out)
        begin
            word_reg   <= word_next;
            found_reg  <= found_next;
            status_reg <= rstat_reg;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (operation == OP_PUSH) && !full)
            mem[fill_reg[AW-1:0]] <= value;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign sts.empty       = empty;
    assign sts.scan_more   = (idx_reg < fill_reg) && !hit_reg;
    assign sts.cmp_pending = cmp_vld_reg;

    assign popped_word = word_reg;
    assign found       = found_reg;
    assign status      = status_reg;

endmodule

>>> hw/rtl/bsws_ctrl.sv
module bsws_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bsws_pkg::dp_status_t sts,
    output bsws_pkg::dp_cmd_t    cmd
);
    import bsws_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (operation == OP_SEARCH) ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if (!sts.scan_more && !sts.cmp_pending)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.rd_en       = 1'b0;
        cmd.rd_sel_scan = 1'b0;
        cmd.scan_issue  = 1'b0;
        cmd.load_out    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = accept;
                cmd.rd_en  = accept && (operation == OP_POP) && !sts.empty;
            end
            S_SCAN:
            begin
                cmd.rd_sel_scan = 1'b1;
                cmd.scan_issue  = sts.scan_more;
                cmd.rd_en       = sts.scan_more;
            end
            S_FINISH:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/bounded_stack_with_search_top.sv
// push, pop and unused codes: S_IDLE takes the input beat, S_FINISH loads the result
// search: S_SCAN reads the stored words, none on an empty stack, and stops early on
// a match; one stored word read per cycle
// one item in flight; the next input beat is taken the cycle after the result
// loads; the result loads once out_valid is low or out_ready is high
// reset (async, active low) empties the stack; memory contents are not cleared
module bounded_stack_with_search_top #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] popped_word,
    output logic               found,
    output logic [1:0]         status
);
    import bsws_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    bsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsws_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .value       (value),
        .sts         (sts),
        .popped_word (popped_word),
        .found       (found),
        .status      (status)
    );

endmodule

>>> hw/rtl/bsws_checker.sv
`include "bounded_stack_with_search_top_macros.svh"

module bsws_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         operation,
    input logic signed [31:0] value,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] popped_word,
    input logic               found,
    input logic [1:0]         status
);
    import bsws_pkg::*;

    // stalled input beat holds
    `BSWS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(operation) && $stable(value))

    // stalled result beat holds
    `BSWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(popped_word) && $stable(status) && $stable(found))

    `BSWS_ASSERT_NOW(a_empty_word, clk, rst_n, out_valid && (status == STAT_EMPTY),
        (popped_word == EMPTY_WORD) && !found)

    `BSWS_ASSERT_NOW(a_full_zero, clk, rst_n, out_valid && (status == STAT_FULL),
        (popped_word == '0) && !found)

    `BSWS_ASSERT_NOW(a_found_ok, clk, rst_n, out_valid && found,
        (status == STAT_OK) && (popped_word == '0))

endmodule

bind bounded_stack_with_search_top bsws_checker u_bsws_checker (.*);
